// ----- design/fme_pkg.sv -----
`default_nettype none
package fme_pkg;

  // Fixed field widths of the item and result beats.
  localparam int JOB_W      = 9;
  localparam int MACH_W     = 5;
  localparam int PTIME_W    = 16;
  localparam int POS_W      = 9;
  localparam int COMP_BITS  = 26;
  localparam int JOBS_REG_W = 10;
  localparam int MACH_REG_W = 6;

  localparam logic [COMP_BITS-1:0] COMP_MAX = {COMP_BITS{1'b1}};

  // Defaults for the top-level parameters.
  localparam int DEF_MAX_JOBS     = 512;
  localparam int DEF_MAX_MACHINES = 32;
  localparam int DEF_TIME_BITS    = 16;

  // Register file layout.
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic REG_JOBS     = 1'b0;
  localparam logic REG_MACHINES = 1'b1;

  localparam logic [JOBS_REG_W-1:0] JOBS_RST = JOBS_REG_W'(1);
  localparam logic [MACH_REG_W-1:0] MACH_RST = MACH_REG_W'(1);

  // Item action codes.
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_EVAL = 1'b1;

  typedef struct packed {
    logic               action;
    logic [JOB_W-1:0]   job;
    logic [MACH_W-1:0]  machine;
    logic [PTIME_W-1:0] proc_time;
    logic [POS_W-1:0]   position;
  } in_beat_t;

  typedef struct packed {
    logic [COMP_BITS-1:0] completion;
    logic                 is_makespan;
  } out_beat_t;

  typedef struct packed {
    logic [JOBS_REG_W-1:0] jobs_in_use;
    logic [MACH_REG_W-1:0] machines_in_use;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

// ----- design/fme_chan_if.sv -----
`default_nettype none
interface fme_chan_if #(
  parameter type beat_t = logic
) ();
  logic  valid;
  logic  ready;
  beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- design/fme_cfg.sv -----
`default_nettype none
module fme_cfg (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [fme_pkg::APB_AW-1:0]  paddr,
  input  wire logic [fme_pkg::APB_DW-1:0]  pwdata,
  output logic      [fme_pkg::APB_DW-1:0]  prdata,
  output logic                             pready,
  output fme_pkg::cfg_t                    cfg
);
  import fme_pkg::*;

  logic [JOBS_REG_W-1:0] jobs_r, jobs_nxt;
  logic [MACH_REG_W-1:0] mach_r, mach_nxt;
  logic                  wr_en;
  logic                  reg_sel;

  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    jobs_nxt = jobs_r;
    mach_nxt = mach_r;
    if (wr_en) begin
      case (reg_sel)
        REG_JOBS:     jobs_nxt = pwdata[JOBS_REG_W-1:0];
        REG_MACHINES: mach_nxt = pwdata[MACH_REG_W-1:0];
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      jobs_r <= JOBS_RST;
      mach_r <= MACH_RST;
    end else begin
      jobs_r <= jobs_nxt;
      mach_r <= mach_nxt;
    end
  end

  always_comb begin
    case (reg_sel)
      REG_JOBS:     prdata = APB_DW'(jobs_r);
      REG_MACHINES: prdata = APB_DW'(mach_r);
      default:      prdata = '0;
    endcase
  end

  assign pready              = 1'b1;
  assign cfg.jobs_in_use     = jobs_r;
  assign cfg.machines_in_use = mach_r;

endmodule
`default_nettype wire

// ----- design/flowshop_makespan_eval_top.sv -----
`default_nettype none
// Permutation flowshop makespan evaluator. A load beat (action 0) writes one processing
// time into the time memory. An evaluate beat (action 1) places a job at a sequence
// position and walks the machines one per cycle: for machine i the completion is the
// job's time plus the larger of the same row's previous machine and the previous
// position's machine i, saturated to 26 bits, and the row is written back to the
// completion memory so that a later evaluation can restart from any position. Positions
// must be evaluated in order; position 0 reads an implicit zero row. An evaluate beat keeps
// the input side busy through the accepting cycle, one memory read per machine on the
// single read port of each memory, the last add and write-back, and the hand-off of the
// result to the output register. When an earlier result still sits untaken in the output
// register, that hand-off waits until the register frees. The result beat carries the
// completion on the last machine and a flag that marks the final position. Results wait
// in an output register, so loads keep flowing while a result is not yet taken.
module flowshop_makespan_eval_top #(
  parameter int MAX_JOBS     = fme_pkg::DEF_MAX_JOBS,
  parameter int MAX_MACHINES = fme_pkg::DEF_MAX_MACHINES,
  parameter int TIME_BITS    = fme_pkg::DEF_TIME_BITS
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  fme_chan_if.sink                         in_ch,
  fme_chan_if.source                       out_ch,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [fme_pkg::APB_AW-1:0]  paddr,
  input  wire logic [fme_pkg::APB_DW-1:0]  pwdata,
  output logic      [fme_pkg::APB_DW-1:0]  prdata,
  output logic                             pready
);
  import fme_pkg::*;

  // Memory address is {job or position, machine}; the machine part is $clog2(MAX_MACHINES) bits wide, at least one.
  localparam int JB      = $clog2(MAX_JOBS);
  localparam int MB      = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
  localparam int AW      = JB + MB;
  localparam int DEPTH   = 2 ** AW;
  localparam int MCW     = $clog2(MAX_MACHINES + 1);
  localparam int SUMW    = ((TIME_BITS > COMP_BITS) ? TIME_BITS : COMP_BITS) + 1;

  cfg_t cfg;

  fme_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // ---------------------------------------------------------------------------
  // Input decode
  // ---------------------------------------------------------------------------
  in_beat_t         in_beat;
  logic             in_fire;
  logic [31:0]      in_job32, in_mach32, in_pos32, in_time32;
  logic [JB-1:0]    in_job_idx, in_pos_idx;
  logic [MB-1:0]    in_mach_idx;
  logic             in_job_ok, in_mach_ok, in_pos_ok;
  logic [MCW-1:0]   act_mach;
  logic             in_last_pos;

  assign in_beat     = in_ch.data;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign in_job32    = 32'(in_beat.job);
  assign in_mach32   = 32'(in_beat.machine);
  assign in_pos32    = 32'(in_beat.position);
  assign in_time32   = 32'(in_beat.proc_time);
  assign in_job_idx  = in_job32[JB-1:0];
  assign in_mach_idx = in_mach32[MB-1:0];
  assign in_pos_idx  = in_pos32[JB-1:0];
  assign in_job_ok   = in_job32 < 32'(MAX_JOBS);
  assign in_mach_ok  = in_mach32 < 32'(MAX_MACHINES);
  assign in_pos_ok   = in_pos32 < 32'(MAX_JOBS);

  // A machine count of zero runs one machine; counts above the build limit are clamped.
  always_comb begin
    if (cfg.machines_in_use == '0) begin
      act_mach = MCW'(1);
    end else if (32'(cfg.machines_in_use) > 32'(MAX_MACHINES)) begin
      act_mach = MCW'(MAX_MACHINES);
    end else begin
      act_mach = MCW'(cfg.machines_in_use);
    end
  end

  assign in_last_pos = (cfg.jobs_in_use != '0) &&
                       (JOBS_REG_W'(in_beat.position) == cfg.jobs_in_use - JOBS_REG_W'(1));

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  state_t           state_r, state_nxt;
  logic             start_eval;
  logic             load_wr;
  logic             issue;
  logic             out_free;

  logic [JB-1:0]    job_idx_r;
  logic [JB-1:0]    pos_idx_r;
  logic [JB-1:0]    prev_idx_r;
  logic             job_ok_r;
  logic             first_row_r;
  logic             last_pos_r;
  logic [MCW-1:0]   m_r;
  logic [MCW-1:0]   iss_idx_r, iss_idx_nxt;

  logic             rd_vld_r, rd_vld_nxt;
  logic             rd_last_r;
  logic [MB-1:0]    rd_idx_r;
  logic [MB-1:0]    iss_mach;

  logic [COMP_BITS-1:0] left_r, left_nxt;
  logic [COMP_BITS-1:0] c_val;

  logic             out_valid_r, out_valid_nxt;
  out_beat_t        out_data_r;

  assign start_eval = in_fire && (in_beat.action == ACT_EVAL) && in_pos_ok;
  assign load_wr    = in_fire && (in_beat.action == ACT_LOAD) && in_job_ok && in_mach_ok;
  assign out_free   = !out_valid_r || out_ch.ready;
  assign iss_mach   = iss_idx_r[MB-1:0];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (start_eval) state_nxt = ST_RUN;
      ST_RUN:  if (rd_vld_r && rd_last_r) state_nxt = ST_DONE;
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State outputs. The last completion write lands as the block enters the done state,
  // before it returns to idle, so the next evaluation's reads always see the finished row.
  always_comb begin
    in_ch.ready = 1'b0;
    issue       = 1'b0;
    case (state_r)
      ST_IDLE: in_ch.ready = 1'b1;
      ST_RUN:  issue       = iss_idx_r < m_r;
      ST_DONE: ;
      default: ;
    endcase
  end

  always_comb begin
    iss_idx_nxt = iss_idx_r;
    if (start_eval) begin
      iss_idx_nxt = '0;
    end else if (issue) begin
      iss_idx_nxt = iss_idx_r + MCW'(1);
    end
  end

  assign rd_vld_nxt = issue;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ch.valid && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (state_r == ST_DONE && out_free) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      iss_idx_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
      iss_idx_r   <= iss_idx_nxt;
    end
  end

  // Per-item context, captured at acceptance.
  always_ff @(posedge clk) begin
    if (start_eval) begin
      job_idx_r   <= in_job_idx;
      job_ok_r    <= in_job_ok;
      pos_idx_r   <= in_pos_idx;
      prev_idx_r  <= (in_pos_idx == '0) ? '0 : in_pos_idx - JB'(1);
      first_row_r <= in_pos_idx == '0;
      last_pos_r  <= in_last_pos;
      m_r         <= act_mach;
    end
    if (issue) begin
      rd_idx_r  <= iss_mach;
      rd_last_r <= iss_idx_r == m_r - MCW'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // Memories: one write and one registered read per cycle each
  // ---------------------------------------------------------------------------
  logic [TIME_BITS-1:0] time_mem [DEPTH];
  logic [COMP_BITS-1:0] comp_mem [DEPTH];
  logic [TIME_BITS-1:0] t_rd_r;
  logic [COMP_BITS-1:0] c_rd_r;
  logic [AW-1:0]        t_waddr, t_raddr, c_waddr, c_raddr;

  assign t_waddr = {in_job_idx, in_mach_idx};
  assign t_raddr = {job_idx_r, iss_mach};
  assign c_raddr = {prev_idx_r, iss_mach};
  assign c_waddr = {pos_idx_r, rd_idx_r};

  always_ff @(posedge clk) begin
    if (load_wr) begin
      time_mem[t_waddr] <= in_time32[TIME_BITS-1:0];
    end
    t_rd_r <= time_mem[t_raddr];
  end

  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      comp_mem[c_waddr] <= c_val;
    end
    c_rd_r <= comp_mem[c_raddr];
  end

  // ---------------------------------------------------------------------------
  // Recurrence: completion = time + max(left, up), saturated
  // ---------------------------------------------------------------------------
  logic [COMP_BITS-1:0] up_val, max_val;
  logic [TIME_BITS-1:0] t_val;
  logic [SUMW-1:0]      sum_val;

  assign up_val  = first_row_r ? '0 : c_rd_r;
  assign t_val   = job_ok_r ? t_rd_r : '0;
  assign max_val = (left_r >= up_val) ? left_r : up_val;
  assign sum_val = SUMW'(max_val) + SUMW'(t_val);
  assign c_val   = (sum_val > SUMW'(COMP_MAX)) ? COMP_MAX : sum_val[COMP_BITS-1:0];

  always_comb begin
    left_nxt = left_r;
    if (start_eval) begin
      left_nxt = '0;
    end else if (rd_vld_r) begin
      left_nxt = c_val;
    end
  end

  always_ff @(posedge clk) begin
    left_r <= left_nxt;
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_data_r.completion  <= left_r;
      out_data_r.is_makespan <= last_pos_r;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

`ifndef SYNTHESIS
  // Reads are only in flight while an evaluation runs.
  a_rd_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> state_r == ST_RUN)
    else $error("memory read pipeline active outside an evaluation");

  // The machine walk never passes the active machine count.
  a_iss_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN |-> iss_idx_r <= m_r)
    else $error("machine counter ran past the machine count");

  // A finished evaluation with a free output register presents its result next cycle.
  a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && !out_valid_r) |=> out_valid_r)
    else $error("finished evaluation did not reach the output register");
`endif

endmodule
`default_nettype wire

// ----- tb/sv/flowshop_makespan_eval_top_tb.sv -----
`default_nettype none
// Testbench for the permutation flowshop makespan evaluator.
module flowshop_makespan_eval_top_tb;
  import fme_pkg::*;

  localparam int NJOBS = DEF_MAX_JOBS;
  localparam int NMACH = DEF_MAX_MACHINES;
  // Quiet cycles waited after the last result so that a trailing load has surely landed.
  localparam int SETTLE_CYCLES = 40;
  localparam int REPORT_LIMIT  = 10;
  // Depth of the in-order sweep with the full route.
  localparam int SWEEP_LEN     = 96;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  fme_chan_if #(.beat_t(in_beat_t))  in_ch ();
  fme_chan_if #(.beat_t(out_beat_t)) out_ch ();

  flowshop_makespan_eval_top u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // The testbench's own picture of the block: the processing time table, the stored
  // completion rows, and the two registers. Written flags and row depths let the
  // stimulus avoid ever reading a table entry that was never written.
  logic [PTIME_W-1:0]    proc_mem     [NJOBS*NMACH];
  bit                    proc_written [NJOBS*NMACH];
  logic [COMP_BITS-1:0]  row_mem      [NJOBS*NMACH];
  int                    row_depth    [NJOBS];
  logic [JOBS_REG_W-1:0] jobs_reg = JOBS_RST;
  logic [MACH_REG_W-1:0] mach_reg = MACH_RST;

  // Completion results that the block still owes, oldest first.
  out_beat_t pending_completions[$];
  // Jobs that already have times loaded, reused so that schedules share jobs.
  logic [JOB_W-1:0] known_jobs[$];

  int tx_idle_pct = 7;
  int rx_idle_pct = 50;
  int loads_sent;
  int evals_sent;
  int results_seen;
  int makespans_seen;
  int mismatches;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The watchdog ends the run if the test hangs, reporting the results still owed.
  initial begin
    #8_000_000;
    $display("watchdog expired with %0d results still owed", pending_completions.size());
    $display("end of test: mismatches");
    $finish;
  end

  function automatic int slot(int job, int mach);
    return job * NMACH + mach;
  endfunction

  // A machine count of zero behaves as one; anything above the table width is clipped.
  function automatic int active_machines();
    if (mach_reg == 0) return 1;
    if (mach_reg > NMACH) return NMACH;
    return int'(mach_reg);
  endfunction

  // Applies one accepted beat to the schedule picture. A load stores a time; an
  // evaluate walks the machines, each completion being the job's time plus the later
  // of the machine to the left and the same machine one position up, saturated.
  function automatic void advance_schedule(in_beat_t b);
    int                   m;
    int                   p;
    logic [COMP_BITS-1:0] left;
    logic [COMP_BITS-1:0] up;
    logic [COMP_BITS-1:0] c;
    logic [COMP_BITS:0]   sum;
    out_beat_t            r;
    if (b.action == ACT_LOAD) begin
      proc_mem[slot(b.job, b.machine)]     = b.proc_time;
      proc_written[slot(b.job, b.machine)] = 1'b1;
      loads_sent++;
      return;
    end
    evals_sent++;
    m    = active_machines();
    p    = int'(b.position);
    left = '0;
    c    = '0;
    for (int i = 0; i < m; i++) begin
      up  = (p > 0) ? row_mem[slot(p - 1, i)] : '0;
      sum = {1'b0, ((left >= up) ? left : up)} + proc_mem[slot(b.job, i)];
      c   = (sum > COMP_MAX) ? COMP_MAX : sum[COMP_BITS-1:0];
      row_mem[slot(p, i)] = c;
      left = c;
    end
    if (row_depth[p] < m) row_depth[p] = m;
    r.completion  = c;
    r.is_makespan = (jobs_reg != 0) && (p == int'(jobs_reg) - 1);
    pending_completions.push_back(r);
  endfunction

  // True when evaluating this job at this position reads only written entries.
  function automatic bit evaluable(int job, int pos);
    int m;
    m = active_machines();
    if (pos > 0 && row_depth[pos - 1] < m) return 1'b0;
    for (int i = 0; i < m; i++)
      if (!proc_written[slot(job, i)]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("MISMATCH at %0t: %s", $time, msg);
  endfunction

  function automatic int random_time();
    case ($urandom_range(9))
      0: return 0;
      1: return 65535;
      2: return $urandom_range(15);
      default: return $urandom_range(65535);
    endcase
  endfunction

  // Result side: the receiver stalls at random, and every accepted result beat is
  // compared with the oldest owed completion.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (pending_completions.size() == 0) begin
        note_mismatch($sformatf("result beat with none owed: completion %0d makespan %0b",
                                out_ch.data.completion, out_ch.data.is_makespan));
      end else begin
        want = pending_completions.pop_front();
        if (want.is_makespan) makespans_seen++;
        if (out_ch.data.completion !== want.completion)
          note_mismatch($sformatf("completion expected %0d actual %0d",
                                  want.completion, out_ch.data.completion));
        if (out_ch.data.is_makespan !== want.is_makespan)
          note_mismatch($sformatf("is_makespan expected %0b actual %0b (completion %0d)",
                                  want.is_makespan, out_ch.data.is_makespan,
                                  want.completion));
      end
    end
  end

  // Sends one beat, idling first at random. Valid is left high after the handshake so
  // that back-to-back beats need no second assignment within one time step.
  task automatic send_beat(in_beat_t b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= b;
    do @(posedge clk); while (!in_ch.ready);
    advance_schedule(b);
  endtask

  // The fields that an action does not use carry random values.
  task automatic load_time(int job, int mach, int t);
    in_beat_t b;
    b.action    = ACT_LOAD;
    b.job       = JOB_W'(job);
    b.machine   = MACH_W'(mach);
    b.proc_time = PTIME_W'(t);
    b.position  = POS_W'($urandom_range(NJOBS - 1));
    send_beat(b);
  endtask

  task automatic eval_position(int job, int pos);
    in_beat_t b;
    b.action    = ACT_EVAL;
    b.job       = JOB_W'(job);
    b.machine   = MACH_W'($urandom_range(NMACH - 1));
    b.proc_time = PTIME_W'($urandom_range(65535));
    b.position  = POS_W'(pos);
    send_beat(b);
  endtask

  // Holds the input side until every owed result has come and the block is quiet.
  task automatic wait_for_idle();
    in_ch.valid <= 1'b0;
    while (pending_completions.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: a setup cycle, then an access cycle that completes while pready is high.
  task automatic write_reg(logic idx, logic [APB_DW-1:0] value);
    wait_for_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_JOBS) begin
      jobs_reg = value[JOBS_REG_W-1:0];
    end else begin
      mach_reg = value[MACH_REG_W-1:0];
    end
  endtask

  task automatic set_shape(int jobs, int machs);
    write_reg(REG_JOBS, APB_DW'(jobs));
    write_reg(REG_MACHINES, APB_DW'(machs));
  endtask

  // Straight after reset one job on one machine, with the smallest and largest times.
  task automatic test_reset_defaults();
    load_time(0, 0, 0);
    eval_position(0, 0);
    load_time(511, 0, 65535);
    eval_position(511, 0);
  endtask

  // A three-job, three-machine schedule, then a re-evaluation from the first changed
  // position after the sender has waited for every owed result.
  task automatic test_small_schedule();
    set_shape(3, 3);
    load_time(5, 0, 0);
    load_time(5, 1, 65535);
    load_time(5, 2, 7);
    load_time(300, 0, 65535);
    load_time(300, 1, 1);
    load_time(300, 2, 16'h5A5A);
    load_time(300, NMACH - 1, 16'hA5A5);
    eval_position(5, 0);
    eval_position(300, 1);
    eval_position(5, 2);
    wait_for_idle();
    eval_position(5, 1);
    eval_position(300, 2);
  endtask

  // A zero job count flags nothing; a zero machine count acts as a single machine.
  task automatic test_register_corners();
    set_shape(0, 0);
    eval_position(300, 0);
    eval_position(5, 1);
  endtask

  // The first SWEEP_LEN positions in order with the widest route, the last one flagged.
  // An oversized machine count acts as the full route, and near-maximum times push the
  // completion into its upper bits. Afterwards a job count beyond the table means the
  // last position is not flagged.
  task automatic test_full_sweep();
    set_shape(SWEEP_LEN, 63);
    for (int i = 0; i < NMACH; i++) load_time(511, i, 65535);
    for (int i = 0; i < NMACH; i++) load_time(170, i, random_time());
    for (int p = 0; p < SWEEP_LEN; p++) eval_position((p % 64 == 7) ? 170 : 511, p);
    set_shape(1023, NMACH);
    eval_position(170, SWEEP_LEN - 3);
    eval_position(511, SWEEP_LEN - 2);
    eval_position(170, SWEEP_LEN - 1);
  endtask

  // One random schedule: pick a shape, load the times its jobs need, evaluate the
  // positions in order, then often alter the sequence and re-evaluate from there.
  task automatic run_schedule_episode();
    int               n;
    int               mreg;
    int               m;
    int               len;
    int               ndist;
    int               start;
    int               k;
    int               swap_at;
    int               sel;
    logic [JOB_W-1:0] tmp;
    logic [JOB_W-1:0] distinct[$];
    logic [JOB_W-1:0] order[$];
    sel = $urandom_range(99);
    if (sel < 80)      n = $urandom_range(8, 1);
    else if (sel < 88) n = $urandom_range(24, 9);
    else if (sel < 92) n = 0;
    else if (sel < 96) n = NJOBS;
    else               n = $urandom_range(1023, NJOBS + 1);
    sel = $urandom_range(99);
    if (sel < 70)      mreg = $urandom_range(6, 1);
    else if (sel < 80) mreg = $urandom_range(NMACH - 1, 7);
    else if (sel < 88) mreg = NMACH;
    else if (sel < 94) mreg = 0;
    else               mreg = $urandom_range(63, NMACH + 1);
    set_shape(n, mreg);
    m     = active_machines();
    len   = (n >= 1 && n <= 24) ? n : $urandom_range(8, 1);
    // Long routes share few jobs so that loading them stays cheap.
    ndist = (m > 6) ? 2 : $urandom_range(len, 1);
    for (int d = 0; d < ndist; d++) begin
      if (known_jobs.size() != 0 && $urandom_range(1))
        distinct.push_back(known_jobs[$urandom_range(known_jobs.size() - 1)]);
      else
        distinct.push_back(JOB_W'($urandom_range(NJOBS - 1)));
    end
    foreach (distinct[d]) begin
      for (int i = 0; i < m; i++)
        if (!proc_written[slot(distinct[d], i)] || $urandom_range(9) < 3)
          load_time(distinct[d], i, random_time());
      known_jobs.push_back(distinct[d]);
      if (known_jobs.size() > 32) void'(known_jobs.pop_front());
    end
    for (int p = 0; p < len; p++) order.push_back(distinct[$urandom_range(ndist - 1)]);

    // Usually the sequence starts at position 0; sometimes it continues a stored row.
    start = 0;
    if ($urandom_range(4) == 0) begin
      k = $urandom_range(NJOBS - len, 1);
      if (row_depth[k - 1] >= m) start = k;
    end
    for (int p = 0; p < len; p++) eval_position(order[p], start + p);

    if ($urandom_range(9) < 6) begin
      k       = $urandom_range(len - 1);
      swap_at = $urandom_range(len - 1, k);
      tmp            = order[k];
      order[k]       = order[swap_at];
      order[swap_at] = tmp;
      if ($urandom_range(1))
        load_time(order[$urandom_range(len - 1, k)], $urandom_range(m - 1), random_time());
      if ($urandom_range(9) == 0) wait_for_idle();
      for (int p = k; p < len; p++) eval_position(order[p], start + p);
    end

    // Noise: a stray load and an out-of-order re-evaluation of one stored position.
    if ($urandom_range(9) < 2) begin
      load_time($urandom_range(NJOBS - 1), $urandom_range(NMACH - 1), random_time());
      k = $urandom_range(len - 1);
      if (evaluable(order[k], start + k)) eval_position(order[k], start + k);
    end
  endtask

  task automatic test_random_schedules(int tx_pct, int rx_pct, int beats);
    int target;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    target      = loads_sent + evals_sent + beats;
    while (loads_sent + evals_sent < target) run_schedule_episode();
  endtask

  initial begin
    rst_n       <= 1'b0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_small_schedule();
    test_register_corners();
    test_full_sweep();
    // The three idling regimes split the random part evenly.
    test_random_schedules(7, 50, 115);
    test_random_schedules(50, 7, 115);
    test_random_schedules(0, 0, 115);

    wait_for_idle();
    $display("covered %0d load beats and %0d evaluate beats over both register extremes",
             loads_sent, evals_sent);
    $display("%0d result beats checked, %0d flagged as makespan, %0d mismatches",
             results_seen, makespans_seen, mismatches);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
`default_nettype wire
